### sv/uer_pkg.sv
`default_nettype none

package uer_pkg;

  // Beat and header geometry.
  localparam int HOLD_BEATS = 6;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] LAST_HDR_IDX = 3'd5;
  localparam logic [IDX_W-1:0] PASS_IDX = 3'd6;
  localparam logic [3:0] BEAT_FULL = 4'd8;
  localparam logic [3:0] BEAT_MIN = 4'd1;
  localparam logic [3:0] MIN_TAIL_BYTES = 4'd2;

  // Protocol codes checked by the classifier.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PORT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_TTL = 8'd1;
  localparam logic [15:0] MATCH_PORT_RESET = 16'd8080;
  localparam logic [7:0] REPLY_TTL_RESET = 8'd64;

  // Payload queue depth between front and back.
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  typedef logic [63:0] word_t;
  typedef logic [HOLD_BEATS-1:0][63:0] hdr_block_t;

  typedef struct packed {
    logic [15:0] match_port;
    logic [7:0]  reply_ttl;
  } cfg_t;

  typedef struct packed {
    word_t      data;
    logic [3:0] bytes;
    logic       last;
  } beat_t;

  // Status of the header slot at the head of the slot queue.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] cnt;
    logic [3:0]       hbv;
    logic             last;
    logic             act;
    logic [15:0]      csum;
  } hdr_meta_t;

  typedef enum logic {
    BK_HDR,
    BK_BODY
  } back_state_t;

endpackage

`default_nettype wire

### sv/uer_if.sv
`default_nettype none

// Input beat channel.
interface uer_in_if ();
  logic        valid;
  logic        ready;
  logic [63:0] beat_data;
  logic [3:0]  beat_bytes;
  logic        beat_last;

  modport source(output valid, beat_data, beat_bytes, beat_last, input ready);
  modport sink(input valid, beat_data, beat_bytes, beat_last, output ready);
endinterface

// Result beat channel.
interface uer_out_if ();
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_bytes;
  logic        out_last;
  logic        out_action;

  modport source(output valid, out_data, out_bytes, out_last, out_action, input ready);
  modport sink(input valid, out_data, out_bytes, out_last, out_action, output ready);
endinterface

// Configuration write channel.
interface uer_cfg_if import uer_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/uer_queue.sv
`default_nettype none

module uer_queue import uer_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  beat_t push_beat,
  output logic  push_ready,
  input  wire   pop,
  output beat_t pop_beat,
  output logic  pop_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  beat_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Status and pointer advance.
  always_comb begin
    push_ready = count_r != CNT_W'(DEPTH);
    pop_valid  = count_r != '0;
    pop_beat   = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

`default_nettype wire

### sv/uer_front.sv
`default_nettype none

module uer_front import uer_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  uer_in_if.sink      in_beat,
  uer_cfg_if.sink     cfg_wr,
  output logic        q_push,
  output beat_t       q_beat,
  input  wire         q_ready,
  input  wire         hdr_pop,
  output hdr_meta_t   hdr_meta,
  output hdr_block_t  hdr_words,
  output cfg_t        cfg
);

  localparam int ACC_W = 20;

  cfg_t              cfg_r;
  logic [IDX_W-1:0]  beat_idx_r, beat_idx_nxt;
  logic [1:0]        slot_busy_r, slot_busy_nxt;
  logic              wr_slot_r, rd_slot_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              eth_ok_r, udp_ok_r, port_ok_r;

  hdr_block_t        hdr_words_r [2];
  logic [IDX_W-1:0]  slot_cnt_r  [2];
  logic [3:0]        slot_hbv_r  [2];
  logic              slot_last_r [2];
  logic              slot_act_r  [2];
  logic [15:0]       slot_csum_r [2];

  logic [3:0]        nb;
  logic [3:0]        hbv_new;
  logic              pass_phase, take, hdr_take, commit, frame_ok;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic [63:0]       d;

  assign cfg_wr.ready = 1'b1;
  assign cfg = cfg_r;
  assign d = in_beat.beat_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_port <= MATCH_PORT_RESET;
      cfg_r.reply_ttl  <= REPLY_TTL_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_MATCH_PORT: cfg_r.match_port <= cfg_wr.data;
        CFG_REPLY_TTL:  cfg_r.reply_ttl  <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  // Accept, classify and decide.
  always_comb begin
    nb = in_beat.beat_bytes;
    if (nb == '0) begin
      nb = BEAT_MIN;
    end else if (nb > BEAT_FULL) begin
      nb = BEAT_FULL;
    end
    pass_phase = beat_idx_r == PASS_IDX;
    in_beat.ready = pass_phase ? q_ready : !slot_busy_r[wr_slot_r];
    take = in_beat.valid && in_beat.ready;
    hdr_take = take && !pass_phase;
    q_push = take && pass_phase;
    q_beat.data = d;
    q_beat.bytes = nb;
    q_beat.last = in_beat.beat_last;
    hbv_new = in_beat.beat_last ? nb : BEAT_FULL;
    commit = hdr_take && (in_beat.beat_last || beat_idx_r == LAST_HDR_IDX);
    frame_ok = (beat_idx_r == LAST_HDR_IDX) && eth_ok_r && udp_ok_r && port_ok_r &&
               (hbv_new >= MIN_TAIL_BYTES);

    // Fold the running header sum into the one's complement checksum.
    fold1 = 17'(acc_r[15:0]) + 17'(acc_r[ACC_W-1:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);

    // Running IPv4 header sum with TTL replaced and the checksum field zero.
    acc_nxt = acc_r;
    if (hdr_take) begin
      case (beat_idx_r)
        3'd1: acc_nxt = ACC_W'(d[15:0]);
        3'd2: acc_nxt = acc_r + ACC_W'(d[63:48]) + ACC_W'(d[47:32]) + ACC_W'(d[31:16]) +
                        ACC_W'({cfg_r.reply_ttl, d[7:0]});
        3'd3: acc_nxt = acc_r + ACC_W'(d[47:32]) + ACC_W'(d[31:16]) + ACC_W'(d[15:0]);
        3'd4: acc_nxt = acc_r + ACC_W'(d[63:48]);
        default: ;
      endcase
    end

    beat_idx_nxt = beat_idx_r;
    if (hdr_take) begin
      if (commit) begin
        beat_idx_nxt = in_beat.beat_last ? '0 : PASS_IDX;
      end else begin
        beat_idx_nxt = beat_idx_r + 1'b1;
      end
    end else if (q_push && in_beat.beat_last) begin
      beat_idx_nxt = '0;
    end

    slot_busy_nxt = slot_busy_r;
    if (hdr_pop) begin
      slot_busy_nxt[rd_slot_r] = 1'b0;
    end
    if (commit) begin
      slot_busy_nxt[wr_slot_r] = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_idx_r  <= '0;
      slot_busy_r <= '0;
      wr_slot_r   <= 1'b0;
      rd_slot_r   <= 1'b0;
      acc_r       <= '0;
      eth_ok_r    <= 1'b0;
      udp_ok_r    <= 1'b0;
      port_ok_r   <= 1'b0;
    end else begin
      beat_idx_r  <= beat_idx_nxt;
      slot_busy_r <= slot_busy_nxt;
      acc_r       <= acc_nxt;
      if (commit) begin
        wr_slot_r <= !wr_slot_r;
      end
      if (hdr_pop) begin
        rd_slot_r <= !rd_slot_r;
      end
      if (hdr_take && beat_idx_r == 3'd1) begin
        eth_ok_r <= d[31:16] == ETHERTYPE_IPV4;
      end
      if (hdr_take && beat_idx_r == 3'd2) begin
        udp_ok_r <= d[7:0] == IP_PROTO_UDP;
      end
      if (hdr_take && beat_idx_r == 3'd4) begin
        port_ok_r <= d[31:16] == cfg_r.match_port;
      end
    end
  end

  // Header slot storage and per-slot decision.
  always_ff @(posedge clk) begin
    if (hdr_take) begin
      hdr_words_r[wr_slot_r][beat_idx_r] <= d;
    end
    if (commit) begin
      slot_cnt_r[wr_slot_r]  <= beat_idx_r + 1'b1;
      slot_hbv_r[wr_slot_r]  <= hbv_new;
      slot_last_r[wr_slot_r] <= in_beat.beat_last;
      slot_act_r[wr_slot_r]  <= frame_ok;
      slot_csum_r[wr_slot_r] <= ~fold2;
    end
  end

  // Head slot seen by the back end.
  always_comb begin
    hdr_meta.valid = slot_busy_r[rd_slot_r];
    hdr_meta.cnt   = slot_cnt_r[rd_slot_r];
    hdr_meta.hbv   = slot_hbv_r[rd_slot_r];
    hdr_meta.last  = slot_last_r[rd_slot_r];
    hdr_meta.act   = slot_act_r[rd_slot_r];
    hdr_meta.csum  = slot_csum_r[rd_slot_r];
    hdr_words      = hdr_words_r[rd_slot_r];
  end

endmodule

`default_nettype wire

### sv/uer_back.sv
`default_nettype none

module uer_back import uer_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  hdr_meta_t   hdr_meta,
  input  hdr_block_t  hdr_words,
  output logic        hdr_pop,
  input  beat_t       q_beat,
  input  wire         q_valid,
  output logic        q_pop,
  input  cfg_t        cfg,
  uer_out_if.source   out_beat
);

  back_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              body_act_r, body_act_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_data_r, data_nxt;
  logic [3:0]        out_bytes_r, bytes_nxt;
  logic              out_last_r, last_nxt;
  logic              out_action_r, action_nxt;
  logic              adv, emit, last_hdr;
  word_t             rw_word;

  // Reflected header word: swapped MACs, addresses and ports, new TTL and checksums.
  function automatic word_t rewrite(hdr_block_t w, logic [IDX_W-1:0] idx,
                                    logic [7:0] ttl, logic [15:0] csum);
    word_t r;
    case (idx)
      3'd0: r = {w[0][15:0], w[1][63:32], w[0][63:48]};
      3'd1: r = {w[0][47:16], w[1][31:0]};
      3'd2: r = {w[2][63:16], ttl, w[2][7:0]};
      3'd3: r = {csum, w[3][15:0], w[4][63:48], w[3][47:32]};
      3'd4: r = {w[3][31:16], w[4][31:16], w[4][47:32], w[4][15:0]};
      3'd5: r = {16'h0000, w[5][47:0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign rw_word = rewrite(hdr_words, idx_r, cfg.reply_ttl, hdr_meta.csum);

  // Release held header beats, then the frame's queued beats.
  always_comb begin
    adv = !out_valid_r || out_beat.ready;
    last_hdr = idx_r == hdr_meta.cnt - 1'b1;
    state_nxt = state_r;
    idx_nxt = idx_r;
    body_act_nxt = body_act_r;
    hdr_pop = 1'b0;
    q_pop = 1'b0;
    emit = 1'b0;
    data_nxt = out_data_r;
    bytes_nxt = out_bytes_r;
    last_nxt = out_last_r;
    action_nxt = out_action_r;
    case (state_r)
      BK_HDR: begin
        if (hdr_meta.valid && adv) begin
          emit = 1'b1;
          data_nxt = hdr_meta.act ? rw_word : hdr_words[idx_r];
          bytes_nxt = last_hdr ? hdr_meta.hbv : BEAT_FULL;
          last_nxt = last_hdr && hdr_meta.last;
          action_nxt = hdr_meta.act;
          if (last_hdr) begin
            idx_nxt = '0;
            hdr_pop = 1'b1;
            body_act_nxt = hdr_meta.act;
            if (!hdr_meta.last) begin
              state_nxt = BK_BODY;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      BK_BODY: begin
        if (q_valid && adv) begin
          emit = 1'b1;
          q_pop = 1'b1;
          data_nxt = q_beat.data;
          bytes_nxt = q_beat.bytes;
          last_nxt = q_beat.last;
          action_nxt = body_act_r;
          if (q_beat.last) begin
            state_nxt = BK_HDR;
          end
        end
      end
      default: begin
        state_nxt = BK_HDR;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_beat.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_HDR;
      idx_r       <= '0;
      body_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      body_act_r  <= body_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= data_nxt;
      out_bytes_r  <= bytes_nxt;
      out_last_r   <= last_nxt;
      out_action_r <= action_nxt;
    end
  end

  assign out_beat.valid      = out_valid_r;
  assign out_beat.out_data   = out_data_r;
  assign out_beat.out_bytes  = out_bytes_r;
  assign out_beat.out_last   = out_last_r;
  assign out_beat.out_action = out_action_r;

endmodule

`default_nettype wire

### sv/udp_echo_reflector.sv
`default_nettype none

// UDP echo reflector. Frames enter as 8-byte big-endian beats and leave in the same
// order, one beat per clock sustained while the output is ready. The first six beats
// of each frame (or fewer if the frame ends earlier) are held in one of two header
// slots; when the sixth or the last beat is taken, the frame is classified (IPv4, UDP,
// destination port equal to match_port, at least 42 header bytes) and the held beats
// are released one per cycle while the output is ready, rewritten as an echo reply when
// the frame matches and unchanged otherwise. Beats after the sixth go through a
// QUEUE_DEPTH-entry queue and carry the frame's action. A beat waits in a header slot
// or the queue, then the output register; header beats wait for the frame's decision,
// so the first beat of a long frame waits for its sixth. Input stalls only when both
// header slots are still draining or the payload queue is full. Configuration writes
// are always taken and should be issued while no frame is in flight.
module udp_echo_reflector import uer_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  uer_in_if.sink     in_beat,
  uer_out_if.source  out_beat,
  uer_cfg_if.sink    cfg_wr
);

  logic        q_push, q_ready, q_pop, q_valid, hdr_pop;
  beat_t       q_push_beat, q_pop_beat;
  hdr_meta_t   hdr_meta;
  hdr_block_t  hdr_words;
  cfg_t        cfg;

  // Accepts beats, holds and classifies headers.
  uer_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cfg_wr    (cfg_wr),
    .q_push    (q_push),
    .q_beat    (q_push_beat),
    .q_ready   (q_ready),
    .hdr_pop   (hdr_pop),
    .hdr_meta  (hdr_meta),
    .hdr_words (hdr_words),
    .cfg       (cfg)
  );

  // Payload beats waiting behind their header.
  uer_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_beat  (q_push_beat),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_beat   (q_pop_beat),
    .pop_valid  (q_valid)
  );

  // Rewrites and emits beats.
  uer_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_meta  (hdr_meta),
    .hdr_words (hdr_words),
    .hdr_pop   (hdr_pop),
    .q_beat    (q_pop_beat),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

### sv/uer_checker.sv
`default_nettype none

module uer_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] out_data,
  input wire [3:0]  out_bytes,
  input wire        out_last,
  input wire        out_action
);

  logic mid_r;
  logic act_r;

  // Track the action of the frame whose beats are being delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
      act_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_r <= !out_last;
      act_r <= out_action;
    end
  end

  // Every beat carries a byte count between one and eight.
  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes >= 4'd1 && out_bytes <= 4'd8))
    else $error("output byte count out of range");

  // A stalled transaction holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_bytes) &&
    $stable(out_last) && $stable(out_action))
    else $error("stalled output transaction changed");

  // All beats of one frame share the same action.
  a_frame_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_action == act_r)
    else $error("action changed within a frame");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind udp_echo_reflector uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_beat.valid),
  .out_ready  (out_beat.ready),
  .out_data   (out_beat.out_data),
  .out_bytes  (out_beat.out_bytes),
  .out_last   (out_beat.out_last),
  .out_action (out_beat.out_action)
);

`default_nettype wire
